// ===== sv/lz4d_pkg.sv =====
`timescale 1ns / 1ps
package lz4d_pkg;

  localparam int HistDepthDefault = 65536;
  localparam logic [23:0] Mask24 = 24'hFFFFFF;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_OFFSET   = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_LASTLIT  = 3'd3,
    ERR_INPUT    = 3'd4
  } err_t;

  typedef enum logic [7:0] {
    PH_TOKEN  = 8'b0000_0001,
    PH_LITEXT = 8'b0000_0010,
    PH_LIT    = 8'b0000_0100,
    PH_OFFLO  = 8'b0000_1000,
    PH_OFFHI  = 8'b0001_0000,
    PH_MATEXT = 8'b0010_0000,
    PH_COPY   = 8'b0100_0000,
    PH_HALT   = 8'b1000_0000
  } phase_t;

  typedef enum logic {
    CFG_INPUT_LENGTH = 1'b0,
    CFG_OUTPUT_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        copy_pending;
    logic        block_done;
    logic [2:0]  error_kind;
    logic [23:0] byte_count;
  } out_item_t;

  // Result of the decoder for one beat, with a possible history write and read.
  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [7:0]  lit_byte;
    logic        out_valid;
    logic        copy_pending;
    logic        block_done;
    logic [2:0]  error_kind;
    logic [23:0] byte_count;
  } dec_res_t;

endpackage

// ===== sv/lz4_block_decompressor_top.sv =====
`timescale 1ns / 1ps
// Channel  Ports                        Direction  Payload
// in       in_valid/in_ready/in_data    input      func, in_byte
// out      out_valid/out_ready/out_data output     out_byte .. byte_count
// cfg      cfg_we/cfg_index/cfg_wdata   input      input_length, output_limit
// One item is taken every cycle while in_ready is high; the history memory
// does one write and one read per cycle. A copy tick gets the byte that
// stage 1 writes then via forwarding, so offset-one matches stream at full rate.
// Reset is synchronous and active low and clears the control state; the
// history is not cleared. A stalled result holds in the output register;
// the input is held off while the beat in stage 1 could not move on, and
// that beat then waits in the skid stage.
module lz4_block_decompressor_top #(
  parameter int HistDepth = lz4d_pkg::HistDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lz4d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lz4d_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_wdata
);
  import lz4d_pkg::*;

  localparam int AddrW = $clog2(HistDepth);

  logic [23:0] inlen_r, outlim_r;
  dec_res_t    res;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]  rd_data, wbyte;
  logic        step;

  // Stage 1: decoded beat waiting for its history byte.
  logic        s1_v_r;
  dec_res_t    s1_r;
  logic        s1_fwd_r;
  logic [7:0]  s1_fwdb_r;
  logic [7:0]  s1_byte;
  out_item_t   s1_item;

  // Output register and skid stage.
  logic        o_v_r, k_v_r;
  out_item_t   o_r, k_r;
  logic        s1_adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inlen_r  <= '0;
      outlim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INPUT_LENGTH: inlen_r  <= cfg_wdata;
        CFG_OUTPUT_LIMIT: outlim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A new beat needs the skid stage free once stage 1 has moved on.
  assign in_ready = !k_v_r && !(s1_v_r && o_v_r && !out_ready);
  assign step = in_valid && in_ready;

  lz4d_decoder #(.HistDepth(HistDepth)) u_dec (
    .clk(clk), .rst_n(rst_n), .step(step), .item(in_data),
    .input_length(inlen_r), .output_limit(outlim_r),
    .res(res), .wr_addr(wr_addr), .rd_addr(rd_addr)
  );

  // Byte written to history: the literal or the copy byte of stage 1.
  assign s1_byte = !s1_r.rd_en ? s1_r.lit_byte : (s1_fwd_r ? s1_fwdb_r : rd_data);

  // Copies and literals both write in stage 1. Keep the port single
  // by writing every beat's byte when it is known in stage 1.
  logic [AddrW-1:0] s1_waddr_r;
  assign wbyte = s1_byte;

  lz4d_history #(.HistDepth(HistDepth)) u_hist (
    .clk(clk), .wr_en(s1_v_r && s1_r.wr_en), .wr_addr(s1_waddr_r), .wr_data(wbyte),
    .rd_en(step && res.rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_comb begin
    s1_item              = '0;
    s1_item.out_byte     = s1_r.out_valid ? s1_byte : 8'd0;
    s1_item.out_valid    = s1_r.out_valid;
    s1_item.copy_pending = s1_r.copy_pending;
    s1_item.block_done   = s1_r.block_done;
    s1_item.error_kind   = s1_r.error_kind;
    s1_item.byte_count   = s1_r.byte_count;
  end

  assign s1_adv = s1_v_r;

  // Stage 1 always moves on: the skid stage gives it room.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= step;
    end
    if (step) begin
      s1_r       <= res;
      s1_waddr_r <= wr_addr;
      // A read of the entry being written this cycle takes the new byte.
      s1_fwd_r   <= s1_v_r && s1_r.wr_en && (s1_waddr_r == rd_addr);
      s1_fwdb_r  <= s1_byte;
    end
  end

  // Output register with skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else begin
      if (!o_v_r || out_ready) begin
        if (k_v_r) begin
          o_v_r <= 1'b1;
          k_v_r <= s1_adv;
        end else begin
          o_v_r <= s1_adv;
        end
      end else if (s1_adv) begin
        k_v_r <= 1'b1;
      end
    end
    if (!o_v_r || out_ready) begin
      if (k_v_r) begin
        o_r <= k_r;
        if (s1_adv) k_r <= s1_item;
      end else if (s1_adv) begin
        o_r <= s1_item;
      end
    end else if (s1_adv) begin
      k_r <= s1_item;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    k_v_r && !out_ready |=> k_v_r) else $error("skid beat lost");
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    k_v_r |-> o_v_r) else $error("skid full with empty output");
  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    k_v_r |-> !in_ready) else $error("input taken with skid full");
`endif

endmodule

// ===== sv/lz4d_history.sv =====
`timescale 1ns / 1ps
module lz4d_history #(
  parameter int HistDepth = lz4d_pkg::HistDepthDefault,
  parameter int AddrW = $clog2(HistDepth)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);
  import lz4d_pkg::*;

  logic [7:0] mem [HistDepth];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lz4d_decoder.sv =====
`timescale 1ns / 1ps
module lz4d_decoder #(
  parameter int HistDepth = lz4d_pkg::HistDepthDefault,
  parameter int AddrW = $clog2(HistDepth)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lz4d_pkg::in_item_t  item,
  input  logic [23:0]         input_length,
  input  logic [23:0]         output_limit,
  output lz4d_pkg::dec_res_t  res,
  output logic [AddrW-1:0]    wr_addr,
  output logic [AddrW-1:0]    rd_addr
);
  import lz4d_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [23:0] run_r, run_nxt;
  logic [15:0] off_r, off_nxt;
  logic [23:0] inpos_r, inpos_nxt;
  logic [23:0] outpos_r, outpos_nxt;
  logic        fin_r, fin_nxt;

  logic [23:0] inp1;
  logic [24:0] lit_sat, mat_sat, run_add;
  logic [23:0] len_l;
  logic [23:0] len_m;
  logic [25:0] o_l12, o_l0, i_l8, i_l0, o_m5;
  logic [15:0] off_full;
  logic        ll_close;

  assign inp1 = inpos_r + 24'd1;
  assign run_add = {1'b0, run_r} + {17'd0, item.in_byte};
  assign lit_sat = run_add;
  assign off_full = {item.in_byte, off_r[7:0]};
  assign wr_addr = outpos_r[AddrW-1:0];
  assign rd_addr = outpos_r[AddrW-1:0] - off_r[AddrW-1:0];

  // Decode step; history traffic is issued through res.
  always_comb begin
    phase_nxt  = phase_r;
    nib_nxt    = nib_r;
    run_nxt    = run_r;
    off_nxt    = off_r;
    inpos_nxt  = inpos_r;
    outpos_nxt = outpos_r;
    fin_nxt    = fin_r;
    res        = '0;
    len_l      = '0;
    len_m      = '0;
    mat_sat    = '0;
    o_l12 = '0; o_l0 = '0; i_l8 = '0; i_l0 = '0; o_m5 = '0;
    ll_close   = 1'b0;
    case (func_t'(item.func))
      FUNC_START: begin
        phase_nxt  = PH_TOKEN;
        nib_nxt    = '0;
        run_nxt    = '0;
        off_nxt    = '0;
        inpos_nxt  = '0;
        outpos_nxt = '0;
        fin_nxt    = 1'b0;
      end
      FUNC_TICK: begin
        if (phase_r == PH_COPY) begin
          res.rd_en     = 1'b1;
          res.wr_en     = 1'b1;
          res.out_valid = 1'b1;
          outpos_nxt    = outpos_r + 24'd1;
          run_nxt       = run_r - 24'd1;
          if (run_r == 24'd1) begin
            phase_nxt = PH_TOKEN;
          end
        end
      end
      FUNC_BYTE: begin
        if (phase_r != PH_COPY && phase_r != PH_HALT) begin
          if (inpos_r >= input_length) begin
            res.error_kind = ERR_INPUT;
            res.byte_count = inpos_r;
            phase_nxt      = PH_HALT;
          end else begin
            inpos_nxt = inp1;
            // Literal length once known: token or last extension byte.
            if (phase_r == PH_TOKEN) begin
              len_l = {20'd0, item.in_byte[7:4]};
            end else begin
              len_l = lit_sat[24] ? Mask24 : lit_sat[23:0];
            end
            o_l0  = {2'b0, outpos_r} + {2'b0, len_l};
            o_l12 = o_l0 + 26'd12;
            i_l0  = {2'b0, inp1} + {2'b0, len_l};
            i_l8  = i_l0 + 26'd8;
            ll_close = (o_l12 > {2'b0, output_limit}) || (i_l8 > {2'b0, input_length});
            // Match length once known.
            if (phase_r == PH_OFFHI) begin
              mat_sat = {21'd0, nib_r} + 25'd4;
            end else begin
              mat_sat = {1'b0, (lit_sat[24] ? Mask24 : lit_sat[23:0])} + 25'd4;
            end
            len_m = mat_sat[24] ? Mask24 : mat_sat[23:0];
            o_m5  = {2'b0, outpos_r} + {2'b0, len_m} + 26'd5;
            unique case (phase_r)
              PH_TOKEN: begin
                if (inp1 == 24'd1 && output_limit == 24'd0) begin
                  if (input_length == 24'd1 && item.in_byte == 8'd0) begin
                    res.block_done = 1'b1;
                  end else begin
                    res.error_kind = (input_length != 24'd1) ? ERR_INPUT : ERR_OVERFLOW;
                  end
                  phase_nxt = PH_HALT;
                end else begin
                  nib_nxt = item.in_byte[3:0];
                  run_nxt = len_l;
                  fin_nxt = 1'b0;
                  if (item.in_byte[7:4] == 4'hF) begin
                    phase_nxt = PH_LITEXT;
                  end else begin
                    phase_nxt = PH_HALT;
                  end
                end
              end
              PH_LITEXT: begin
                run_nxt = len_l;
                phase_nxt = PH_LITEXT;
                if (!(item.in_byte == 8'hFF && ({1'b0, inp1} + 25'd15) < {1'b0, input_length})) begin
                  phase_nxt = PH_HALT;
                end
              end
              PH_LIT: begin
                res.wr_en     = 1'b1;
                res.lit_byte  = item.in_byte;
                res.out_valid = 1'b1;
                outpos_nxt    = outpos_r + 24'd1;
                run_nxt       = run_r - 24'd1;
                if (run_r == 24'd1) begin
                  if (fin_r) begin
                    res.block_done = 1'b1;
                    res.byte_count = outpos_r + 24'd1;
                    phase_nxt      = PH_HALT;
                  end else begin
                    phase_nxt = PH_OFFLO;
                  end
                end
              end
              PH_OFFLO: begin
                off_nxt   = {8'd0, item.in_byte};
                phase_nxt = PH_OFFHI;
              end
              PH_OFFHI: begin
                off_nxt = off_full;
                if (off_full == 16'd0 || {8'd0, off_full} > outpos_r) begin
                  res.error_kind = ERR_OFFSET;
                  res.byte_count = inp1;
                  phase_nxt      = PH_HALT;
                end else if (nib_r == 4'hF) begin
                  run_nxt   = 24'd15;
                  phase_nxt = PH_MATEXT;
                end else if (o_m5 > {2'b0, output_limit}) begin
                  res.error_kind = ERR_LASTLIT;
                  res.byte_count = inp1;
                  phase_nxt      = PH_HALT;
                end else begin
                  run_nxt   = len_m;
                  phase_nxt = PH_COPY;
                end
              end
              PH_MATEXT: begin
                if (({1'b0, inp1} + 25'd5) > {1'b0, input_length}) begin
                  res.error_kind = ERR_INPUT;
                  res.byte_count = inp1;
                  phase_nxt      = PH_HALT;
                end else begin
                  run_nxt = len_l;
                  if (item.in_byte != 8'hFF) begin
                    if (o_m5 > {2'b0, output_limit}) begin
                      res.error_kind = ERR_LASTLIT;
                      res.byte_count = inp1;
                      phase_nxt      = PH_HALT;
                    end else begin
                      run_nxt   = len_m;
                      phase_nxt = PH_COPY;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
            // Closing literal-length handling shared by token and extension.
            if ((phase_r == PH_TOKEN && !(inp1 == 24'd1 && output_limit == 24'd0) &&
                 item.in_byte[7:4] != 4'hF) ||
                (phase_r == PH_LITEXT && phase_nxt == PH_HALT)) begin
              if (ll_close && i_l0 != {2'b0, input_length}) begin
                res.error_kind = ERR_INPUT;
                res.byte_count = inp1;
                phase_nxt      = PH_HALT;
              end else if (ll_close && o_l0 > {2'b0, output_limit}) begin
                res.error_kind = ERR_OVERFLOW;
                res.byte_count = inp1;
                phase_nxt      = PH_HALT;
              end else begin
                if (ll_close) begin
                  fin_nxt = 1'b1;
                end
                if (len_l != 24'd0) begin
                  phase_nxt = PH_LIT;
                end else if (ll_close) begin
                  res.block_done = 1'b1;
                  res.byte_count = outpos_r;
                  phase_nxt      = PH_HALT;
                end else begin
                  phase_nxt = PH_OFFLO;
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.copy_pending = (phase_nxt == PH_COPY);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TOKEN;
      nib_r    <= '0;
      run_r    <= '0;
      off_r    <= '0;
      inpos_r  <= '0;
      outpos_r <= '0;
      fin_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      nib_r    <= nib_nxt;
      run_r    <= run_nxt;
      off_r    <= off_nxt;
      inpos_r  <= inpos_nxt;
      outpos_r <= outpos_nxt;
      fin_r    <= fin_nxt;
    end
  end

`ifndef SYNTHESIS
  a_copy_only_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.rd_en |-> phase_r == PH_COPY) else $error("copy read outside copy");
  a_outpos_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.wr_en |=> outpos_r == $past(outpos_r) + 24'd1)
    else $error("output position did not advance");
  a_done_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.block_done && res.error_kind != ERR_NONE)) else $error("done with error");
`endif

endmodule
